// ----- sv/clr_pkg.sv -----
// Shared constants, types and helper functions of the clamped line rasterizer.
`default_nettype none

package clr_pkg;

    // Largest image side and the widths that follow from it.
    localparam int MAX_DIM  = 64;
    localparam int COORD_W  = $clog2(MAX_DIM);
    localparam int DIM_W    = COORD_W + 1;
    localparam int ADDR_W   = 2 * COORD_W;
    localparam int ERR_W    = COORD_W + 2;
    localparam int IN_W     = 10;
    localparam int COLOR_W  = 32;

    // Configuration register indexes.
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic setup;
        logic step;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic last;
    } t_status;

    // Map a written dimension into 1..MAX_DIM.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        begin
            if (v == '0) begin
                res = DIM_W'(1);
            end else if (v > DIM_W'(MAX_DIM)) begin
                res = DIM_W'(MAX_DIM);
            end else begin
                res = v;
            end
            return res;
        end
    endfunction

    // Saturate a signed coordinate into 0..dim-1.
    function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [IN_W-1:0] v,
                                                       input logic [DIM_W-1:0] dim);
        logic [IN_W-1:0]    lim;
        logic [COORD_W-1:0] res;
        begin
            lim = IN_W'(dim - DIM_W'(1));
            if (v[IN_W-1]) begin
                res = '0;
            end else if (v > lim) begin
                res = lim[COORD_W-1:0];
            end else begin
                res = v[COORD_W-1:0];
            end
            return res;
        end
    endfunction

endpackage

`default_nettype wire

// ----- sv/clr_ctrl.sv -----
// Controller state machine that sequences load, setup and pixel stepping.
`default_nettype none

module clr_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  clr_pkg::t_status     i_status,
    output clr_pkg::t_cmd        o_cmd,
    output logic                 o_busy
);
    import clr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } t_state;

    t_state r_state;
    t_state n_state;

    // Commands follow from the state and the datapath status.
    always_comb begin
        o_cmd.load  = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.setup = (r_state == ST_SETUP);
        o_cmd.step  = (r_state == ST_RUN) && i_status.out_free;
        o_busy      = (r_state != ST_IDLE);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (i_status.out_free && i_status.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- sv/clr_datapath.sv -----
// Datapath: configuration, endpoint clamping, Bresenham stepping and output register.
`default_nettype none

module clr_datapath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  clr_pkg::t_cmd                        i_cmd,
    output clr_pkg::t_status                     o_status,
    input  wire logic                            i_cfg_we,
    input  wire logic                            i_cfg_index,
    input  wire logic [clr_pkg::DIM_W-1:0]       i_cfg_data,
    input  wire logic signed [clr_pkg::IN_W-1:0] i_start_x,
    input  wire logic signed [clr_pkg::IN_W-1:0] i_start_y,
    input  wire logic signed [clr_pkg::IN_W-1:0] i_end_x,
    input  wire logic signed [clr_pkg::IN_W-1:0] i_end_y,
    input  wire logic [clr_pkg::COLOR_W-1:0]     i_red_value,
    input  wire logic [clr_pkg::COLOR_W-1:0]     i_green_value,
    input  wire logic [clr_pkg::COLOR_W-1:0]     i_blue_value,
    input  wire logic                            i_out_stall,
    output logic                                 o_out_valid,
    output logic [clr_pkg::COORD_W-1:0]          o_pixel_x,
    output logic [clr_pkg::COORD_W-1:0]          o_pixel_y,
    output logic [clr_pkg::ADDR_W-1:0]           o_pixel_address,
    output logic [clr_pkg::COLOR_W-1:0]          o_red_out,
    output logic [clr_pkg::COLOR_W-1:0]          o_green_out,
    output logic [clr_pkg::COLOR_W-1:0]          o_blue_out,
    output logic                                 o_last_pixel
);
    import clr_pkg::*;

    // Configuration, stored already mapped into the legal range.
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;

    // Line state.
    logic [COORD_W-1:0]      r_cx, r_cy, r_ex, r_ey;
    logic [COORD_W-1:0]      r_major, r_minor, r_count;
    logic                    r_x_major, r_sx, r_sy;
    logic signed [ERR_W-1:0] r_err;
    logic [COLOR_W-1:0]      r_red, r_green, r_blue;

    // Output register.
    logic                    r_out_valid;
    logic [COORD_W-1:0]      r_px, r_py;
    logic [ADDR_W-1:0]       r_addr;
    logic [COLOR_W-1:0]      r_ored, r_ogreen, r_oblue;
    logic                    r_last;

    // Setup arithmetic.
    logic               sx, sy, x_major;
    logic [COORD_W-1:0] dx, dy, major, minor;

    // Step arithmetic.
    logic signed [ERR_W-1:0] err_sum;
    logic                    minor_step;
    logic [ADDR_W:0]         addr_full;
    logic [COORD_W-1:0]      cx_next, cy_next;
    logic [COORD_W-1:0]      inc_x, inc_y;

    // Spans, directions and the major axis of the clamped line.
    always_comb begin
        sx      = (r_cx < r_ex);
        sy      = (r_cy < r_ey);
        dx      = sx ? (r_ex - r_cx) : (r_cx - r_ex);
        dy      = sy ? (r_ey - r_cy) : (r_cy - r_ey);
        x_major = (dx >= dy);
        major   = x_major ? dx : dy;
        minor   = x_major ? dy : dx;
    end

    // Error update and the next pixel position.
    always_comb begin
        err_sum    = r_err + $signed({2'b00, r_minor});
        minor_step = !err_sum[ERR_W-1] && (err_sum != '0);
        inc_x      = r_sx ? COORD_W'(1) : {COORD_W{1'b1}};
        inc_y      = r_sy ? COORD_W'(1) : {COORD_W{1'b1}};
        cx_next    = r_cx;
        cy_next    = r_cy;
        if (r_x_major) begin
            cx_next = r_cx + inc_x;
            if (minor_step) begin
                cy_next = r_cy + inc_y;
            end
        end else begin
            cy_next = r_cy + inc_y;
            if (minor_step) begin
                cx_next = r_cx + inc_x;
            end
        end
        addr_full = (ADDR_W + 1)'(r_cy * r_width) + (ADDR_W + 1)'(r_cx);
    end

    // Status toward the controller.
    always_comb begin
        o_status.out_free = !r_out_valid || !i_out_stall;
        o_status.last     = (r_count == '0);
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(MAX_DIM);
            r_height <= DIM_W'(MAX_DIM);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_width  <= eff_dim(i_cfg_data);
                CFG_IMAGE_HEIGHT: r_height <= eff_dim(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // Line registers: clamp at load, derive spans at setup, walk at step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx    <= clamp_coord(i_start_x, r_width);
            r_cy    <= clamp_coord(i_start_y, r_height);
            r_ex    <= clamp_coord(i_end_x, r_width);
            r_ey    <= clamp_coord(i_end_y, r_height);
            r_red   <= i_red_value;
            r_green <= i_green_value;
            r_blue  <= i_blue_value;
        end else if (i_cmd.setup) begin
            r_sx      <= sx;
            r_sy      <= sy;
            r_x_major <= x_major;
            r_major   <= major;
            r_minor   <= minor;
            r_count   <= major;
            r_err     <= ERR_W'(0) - $signed({2'b00, major >> 1});
        end else if (i_cmd.step) begin
            r_cx    <= cx_next;
            r_cy    <= cy_next;
            r_count <= r_count - COORD_W'(1);
            r_err   <= minor_step ? (err_sum - $signed({2'b00, r_major})) : err_sum;
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_px     <= r_cx;
            r_py     <= r_cy;
            r_addr   <= addr_full[ADDR_W-1:0];
            r_ored   <= r_red;
            r_ogreen <= r_green;
            r_oblue  <= r_blue;
            r_last   <= (r_count == '0);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pixel_x       = r_px;
    assign o_pixel_y       = r_py;
    assign o_pixel_address = r_addr;
    assign o_red_out       = r_ored;
    assign o_green_out     = r_ogreen;
    assign o_blue_out      = r_oblue;
    assign o_last_pixel    = r_last;

endmodule

`default_nettype wire

// ----- sv/clamped_line_rasterizer.sv -----
// Top level of the clamped line rasterizer: controller plus datapath.
//
// Channel   Direction  Handshake                Payload
// request   in         i_in_valid / o_in_stall  endpoints, color words
// pixel     out        o_out_valid / i_out_stall position, address, color, last flag
// config    in         i_cfg_we                 i_cfg_index, i_cfg_data
//
// A line is loaded, set up and then stepped pixel by pixel along the major axis;
// the pixel stepper in the datapath emits one pixel per cycle while the pixel
// channel does not stall.
// Reset is synchronous and active low; the image size returns to MAX_DIM.
// A stall on the pixel channel freezes the stepper; the last pixel of a line
// may still wait in the output register while the next request is accepted.
`default_nettype none

module clamped_line_rasterizer (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic                            i_cfg_index,
    input  wire logic [clr_pkg::DIM_W-1:0]       i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic signed [clr_pkg::IN_W-1:0] i_start_x,
    input  wire logic signed [clr_pkg::IN_W-1:0] i_start_y,
    input  wire logic signed [clr_pkg::IN_W-1:0] i_end_x,
    input  wire logic signed [clr_pkg::IN_W-1:0] i_end_y,
    input  wire logic [clr_pkg::COLOR_W-1:0]     i_red_value,
    input  wire logic [clr_pkg::COLOR_W-1:0]     i_green_value,
    input  wire logic [clr_pkg::COLOR_W-1:0]     i_blue_value,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [clr_pkg::COORD_W-1:0]          o_pixel_x,
    output logic [clr_pkg::COORD_W-1:0]          o_pixel_y,
    output logic [clr_pkg::ADDR_W-1:0]           o_pixel_address,
    output logic [clr_pkg::COLOR_W-1:0]          o_red_out,
    output logic [clr_pkg::COLOR_W-1:0]          o_green_out,
    output logic [clr_pkg::COLOR_W-1:0]          o_blue_out,
    output logic                                 o_last_pixel
);
    import clr_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    busy;

    // Sequencer.
    clr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    // Arithmetic and storage.
    clr_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .i_red_value     (i_red_value),
        .i_green_value   (i_green_value),
        .i_blue_value    (i_blue_value),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_pixel_address (o_pixel_address),
        .o_red_out       (o_red_out),
        .o_green_out     (o_green_out),
        .o_blue_out      (o_blue_out),
        .o_last_pixel    (o_last_pixel)
    );

    // New requests are taken only while the sequencer is idle.
    assign o_in_stall = busy;

endmodule

`default_nettype wire

// ----- sv/clr_checker.sv -----
// Port-level checker for the clamped line rasterizer and its bind statement.
`default_nettype none

module clr_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_stall,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic [clr_pkg::COORD_W-1:0] o_pixel_x,
    input wire logic [clr_pkg::COORD_W-1:0] o_pixel_y,
    input wire logic                        o_last_pixel
);
    import clr_pkg::*;

    // A pixel held by a stall stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pixel_x)
            && $stable(o_pixel_y) && $stable(o_last_pixel))
        else $error("stalled pixel changed or vanished");

    // A line in flight keeps new requests out.
    a_busy_mid_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_pixel |-> o_in_stall)
        else $error("request channel open while a line is unfinished");

    // An accepted request is followed by a setup cycle.
    a_setup_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("no setup cycle after an accepted request");

    // The setup cycle produces no new pixel of the fresh line.
    a_no_pixel_in_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !(o_out_valid && !o_last_pixel))
        else $error("mid-line pixel right after an accepted request");

endmodule

bind clamped_line_rasterizer clr_checker u_clr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_pixel_x    (o_pixel_x),
    .o_pixel_y    (o_pixel_y),
    .o_last_pixel (o_last_pixel)
);

`default_nettype wire
